// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int CHAR_W       = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int ROWS_CFG_W   = 6;
    localparam int COLS_CFG_W   = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int OUT_ROW_W    = 5;
    localparam int OUT_COL_W    = 8;
    localparam int LOCATION_W   = 16;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam int                CURSOR_PITCH = 80;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the input item
        logic clr_wr;   // reset sweep: write one space cell
        logic exec;     // carry out a read, a put or a newline; a scrolling newline restarts the sweep address
        logic scr_rd;   // scroll: read the cell one row below
        logic scr_wr;   // scroll: write the fetched cell one row up
        logic fill_wr;  // scroll: write a space into the last row
        logic nl_fin;   // scroll done: cursor to start of the last row
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_scroll;
        logic clr_last;
        logic copy_phase;
        logic fill_last;
    } t_stat;

endpackage

// ===== sv/tcw_ctrl.sv =====
// Sequencing state machine of the text console writer.
module tcw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCR_RD = 6'b001000,
        S_SCR_WR = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.needs_scroll ? S_SCR_RD : S_DONE;
            end
            S_SCR_RD: begin
                if (i_stat.copy_phase) begin
                    o_cmd.scr_rd = 1'b1;
                    n_state      = S_SCR_WR;
                end else begin
                    o_cmd.fill_wr = 1'b1;
                    if (i_stat.fill_last) begin
                        o_cmd.nl_fin = 1'b1;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SCR_WR: begin
                o_cmd.scr_wr = 1'b1;
                n_state      = S_SCR_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== sv/tcw_datapath.sv =====
// Cell store, cursor and configuration registers of the text console writer.
module tcw_datapath #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_cmd                    i_cmd,
    output tcw_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::READ_ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::READ_COL_W-1:0]   i_read_column,
    output logic [tcw_pkg::CHAR_W-1:0]       o_cell_data,
    output logic [tcw_pkg::OUT_ROW_W-1:0]    o_cursor_row_now,
    output logic [tcw_pkg::OUT_COL_W-1:0]    o_cursor_column_now,
    output logic                             o_cursor_shown,
    output logic [tcw_pkg::LOCATION_W-1:0]   o_cursor_location
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACW   = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);

    logic [tcw_pkg::CHAR_W-1:0] mem [DEPTH];

    logic [tcw_pkg::ROWS_CFG_W-1:0] r_rows_cfg;
    logic [tcw_pkg::COLS_CFG_W-1:0] r_cols_cfg;

    logic [AW-1:0]                 r_addr;
    logic [RW-1:0]                 r_row, n_row;
    logic [CW-1:0]                 r_col, n_col;
    logic                          r_shown;
    logic [tcw_pkg::LOCATION_W-1:0] r_loc;

    logic                          r_op;
    logic [tcw_pkg::CHAR_W-1:0]    r_code;
    logic [tcw_pkg::READ_ROW_W-1:0] r_rrow;
    logic [tcw_pkg::READ_COL_W-1:0] r_rcol;
    logic                          r_rd_ok;
    logic [tcw_pkg::CHAR_W-1:0]    r_q;

    logic [ERW-1:0]                eff_rows;
    logic [CW-1:0]                 eff_cols;
    logic                          is_newline;
    logic                          needs_scroll;
    logic                          write_ok;
    logic                          upd_cursor;
    logic                          n_shown;
    logic [ACW-1:0]                copy_end;
    logic [ACW-1:0]                fill_end;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [tcw_pkg::CHAR_W-1:0]    wdata;
    logic                          re;
    logic [AW-1:0]                 raddr;

    // out-of-range register values clamp to the usable size
    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = ERW'(1);
        end else if (32'(r_rows_cfg) > MAX_ROWS) begin
            eff_rows = ERW'(MAX_ROWS);
        end else begin
            eff_rows = ERW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = CW'(1);
        end else if (32'(r_cols_cfg) > MAX_COLUMNS) begin
            eff_cols = CW'(MAX_COLUMNS);
        end else begin
            eff_cols = CW'(r_cols_cfg);
        end
    end

    assign is_newline   = (r_code == tcw_pkg::NEWLINE_CODE);
    // a cursor below the last row (rows shrank) scrolls as on the last row
    assign needs_scroll = (r_op == tcw_pkg::OP_PUT) && is_newline
                          && (32'(r_row) + 32'd1 >= 32'(eff_rows));
    assign write_ok     = (32'(r_row) < 32'(eff_rows)) && (32'(r_col) < 32'(eff_cols));

    // scroll moves rows 1..last up, then blanks the last row: one address sweep
    assign copy_end = ACW'((32'(eff_rows) - 32'd1) * MAX_COLUMNS);
    assign fill_end = ACW'(32'(eff_rows) * MAX_COLUMNS - 1);

    assign o_stat.needs_scroll = needs_scroll;
    assign o_stat.clr_last     = (r_addr == AW'(DEPTH - 1));
    assign o_stat.copy_phase   = (ACW'(r_addr) < copy_end);
    assign o_stat.fill_last    = (ACW'(r_addr) == fill_end);

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        upd_cursor = 1'b0;
        if (i_cmd.exec && (r_op == tcw_pkg::OP_PUT) && !needs_scroll) begin
            upd_cursor = 1'b1;
            if (is_newline) begin
                n_row = r_row + RW'(1);
                n_col = '0;
            end else if (write_ok) begin
                n_col = r_col + CW'(1);
            end
        end
        if (i_cmd.nl_fin) begin
            upd_cursor = 1'b1;
            n_row      = RW'(32'(eff_rows) - 32'd1);
            n_col      = '0;
        end
        n_shown = (32'(n_col) < 32'(eff_cols)) && (32'(n_row) < 32'(eff_rows));
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = tcw_pkg::SPACE_CODE;
        re    = 1'b0;
        raddr = AW'(32'(r_rrow) * MAX_COLUMNS + 32'(r_rcol));
        if (i_cmd.clr_wr || i_cmd.fill_wr) begin
            we = 1'b1;
        end
        if (i_cmd.scr_wr) begin
            we    = 1'b1;
            wdata = r_q;
        end
        if (i_cmd.exec) begin
            if (r_op == tcw_pkg::OP_READ) begin
                re = 1'b1;
            end else if (!is_newline && write_ok) begin
                we    = 1'b1;
                waddr = AW'(32'(r_row) * MAX_COLUMNS + 32'(r_col));
                wdata = r_code;
            end
        end
        if (i_cmd.scr_rd) begin
            re    = 1'b1;
            raddr = AW'(32'(r_addr) + MAX_COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= tcw_pkg::ROWS_CFG_W'(25);
            r_cols_cfg <= tcw_pkg::COLS_CFG_W'(80);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcw_pkg::REG_ROWS_IN_USE: begin
                    r_rows_cfg <= i_cfg_data[tcw_pkg::ROWS_CFG_W-1:0];
                end
                tcw_pkg::REG_COLUMNS_IN_USE: begin
                    r_cols_cfg <= i_cfg_data[tcw_pkg::COLS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_shown <= 1'b1;
            r_loc   <= '0;
        end else begin
            if (i_cmd.exec && needs_scroll) begin
                r_addr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.scr_wr || i_cmd.fill_wr) begin
                r_addr <= r_addr + AW'(1);
            end
            r_row <= n_row;
            r_col <= n_col;
            if (upd_cursor) begin
                r_shown <= n_shown;
                if (n_shown) begin
                    r_loc <= tcw_pkg::LOCATION_W'(32'(n_row) * tcw_pkg::CURSOR_PITCH
                                                  + 32'(n_col));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_code  <= i_char_code;
            r_rrow  <= i_read_row;
            r_rcol  <= i_read_column;
            r_rd_ok <= (i_op == tcw_pkg::OP_READ)
                       && (32'(i_read_row) < 32'(eff_rows))
                       && (32'(i_read_column) < 32'(eff_cols));
        end
    end

    assign o_cell_data         = r_rd_ok ? r_q : '0;
    assign o_cursor_row_now    = tcw_pkg::OUT_ROW_W'(r_row);
    assign o_cursor_column_now = tcw_pkg::OUT_COL_W'(r_col);
    assign o_cursor_shown      = r_shown;
    assign o_cursor_location   = r_loc;

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer: MAX_ROWS x MAX_COLUMNS character store with cursor and scroll.
// After reset the block clears the cell store to spaces, one cell a cycle, with busy
// high; configuration writes are taken meanwhile. An item is taken when start is high
// and busy low. A read, a stored character and a newline that does not scroll pass
// through S_EXEC and S_DONE; the result is shown for one cycle with o_done, in the last
// cycle of busy, and cannot be held off. A newline on the last row in use scrolls
// through the single-port cell store: each cell moved up is read in S_SCR_RD and
// written one row up in S_SCR_WR, then each cell of the last row gets a space.
module text_console_writer #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::READ_ROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::READ_COL_W-1:0]   i_read_column,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_done,
    output logic [tcw_pkg::CHAR_W-1:0]       o_cell_data,
    output logic [tcw_pkg::OUT_ROW_W-1:0]    o_cursor_row_now,
    output logic [tcw_pkg::OUT_COL_W-1:0]    o_cursor_column_now,
    output logic                             o_cursor_shown,
    output logic [tcw_pkg::LOCATION_W-1:0]   o_cursor_location
);

    tcw_pkg::t_cmd  cmd;
    tcw_pkg::t_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    tcw_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_op                (i_op),
        .i_char_code         (i_char_code),
        .i_read_row          (i_read_row),
        .i_read_column       (i_read_column),
        .o_cell_data         (o_cell_data),
        .o_cursor_row_now    (o_cursor_row_now),
        .o_cursor_column_now (o_cursor_column_now),
        .o_cursor_shown      (o_cursor_shown),
        .o_cursor_location   (o_cursor_location)
    );

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level assertions of the text console writer and their bind.
module tcw_checker #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 128
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic                           o_cursor_shown,
    input logic [tcw_pkg::OUT_ROW_W-1:0]  o_cursor_row_now,
    input logic [tcw_pkg::OUT_COL_W-1:0]  o_cursor_column_now,
    input logic [tcw_pkg::LOCATION_W-1:0] o_cursor_location
);

    localparam bit ROW_FITS = (MAX_ROWS <= 32) && (MAX_COLUMNS > 0);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobed while idle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // with o_done high, a shown cursor carries the position of the reported row and column
    a_location: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ROW_FITS && o_done && o_cursor_shown) |->
        (o_cursor_location == tcw_pkg::LOCATION_W'(32'(o_cursor_row_now)
                              * tcw_pkg::CURSOR_PITCH + 32'(o_cursor_column_now))))
        else $error("cursor location does not match row and column");

endmodule

bind text_console_writer tcw_checker #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
) u_tcw_checker (.*);
